// ----- rtl/core/elevation_color_ramp_assert.svh -----
// Assertion macros for the color ramp block.
// Used by elevation_color_ramp; needs clk and rst in the including scope.
`ifndef ELEVATION_COLOR_RAMP_ASSERT_SVH
`define ELEVATION_COLOR_RAMP_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must hold at every edge out of reset
`define ECR_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// pre implies post in the same cycle
`define ECR_ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// pre implies post in the next cycle
`define ECR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ECR_ASSERT_ALWAYS(name, cond, msg)
`define ECR_ASSERT_IMPLY(name, pre, post, msg)
`define ECR_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ----- rtl/core/ecr_pkg.sv -----
// Shared types, widths and codes for the color ramp block.
// No dependencies; imported by ecr_div and elevation_color_ramp.
package ecr_pkg;

  localparam int ENTRIES_DEF       = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int ELEV_W    = 32;
  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;
  localparam int ACT_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MAP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW         = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY_RANGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX     = 2'd3;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elev;
    logic [COLOR_W-1:0]       color;
  } ecr_entry_t;

endpackage

// ----- rtl/core/ecr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on ecr_pkg; instantiated by elevation_color_ramp.
module ecr_div #(
  parameter int IDX_W         = $clog2(ecr_pkg::ENTRIES_DEF),
  parameter int FRACTION_BITS = ecr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [ecr_pkg::ELEV_W+IDX_W-1:0]         dividend,
  input  logic [ecr_pkg::ELEV_W-1:0]               divisor,
  output logic                                     done,
  output logic [IDX_W+FRACTION_BITS-1:0]           quotient
);
  import ecr_pkg::*;

  localparam int DW    = ELEV_W + IDX_W;
  localparam int QW    = IDX_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [ELEV_W-1:0] rem;
  logic [ELEV_W-1:0] dvsr;
  logic [QW-1:0]     work;
  logic [ELEV_W:0]   trial;
  logic [ELEV_W:0]   trial_sub;
  logic              fits;

  // work holds dividend bits still to shift in at the top, quotient bits at the bottom
  assign trial     = {rem, work[QW-1]};
  assign trial_sub = trial - {1'b0, dvsr};
  assign fits      = (trial >= {1'b0, dvsr});
  assign quotient  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits are known to lie below the divisor
      rem  <= dividend[DW-1:IDX_W];
      work <= {dividend[IDX_W-1:0], {FRACTION_BITS{1'b0}}};
      dvsr <= divisor;
    end else if (busy) begin
      rem  <= fits ? trial_sub[ELEV_W-1:0] : trial[ELEV_W-1:0];
      work <= {work[QW-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/elevation_color_ramp.sv -----
// Piecewise linear color ramp over a sorted breakpoint table; uses ecr_pkg and ecr_div.
// One item at a time. Insert walks down the table, moving entries up; Clear resets the count.
// Map, relative: multiply, divide, read both bracket ends, mix; absolute: table scan, divide, mix.
// The next item is taken after the result load.
// Sync reset clears control and entry count and restores config defaults; table contents stay undefined.
`include "elevation_color_ramp_assert.svh"
module elevation_color_ramp #(
  parameter int ENTRIES       = ecr_pkg::ENTRIES_DEF,
  parameter int FRACTION_BITS = ecr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item channel
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [ecr_pkg::ACT_W-1:0]             action,
  input  logic signed [ecr_pkg::ELEV_W-1:0]     elevation,
  input  logic [ecr_pkg::CH_W-1:0]              entry_red,
  input  logic [ecr_pkg::CH_W-1:0]              entry_green,
  input  logic [ecr_pkg::CH_W-1:0]              entry_blue,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [ecr_pkg::CH_W-1:0]              red,
  output logic [ecr_pkg::CH_W-1:0]              green,
  output logic [ecr_pkg::CH_W-1:0]              blue,
  output logic [ecr_pkg::STATUS_W-1:0]          status,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ecr_pkg::CFG_DAT_W-1:0]         cfg_data
);
  import ecr_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int QW = IW + FRACTION_BITS;
  localparam int DW = ELEV_W + IW;

  localparam logic [NW-1:0] FULL_COUNT = NW'(ENTRIES);
  localparam logic [NW-1:0] MIN_MAP    = NW'(2);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_DIVGO   = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_END_RD  = 4'd8;
  localparam logic [3:0] S_REL_LO  = 4'd9;
  localparam logic [3:0] S_REL_HI  = 4'd10;
  localparam logic [3:0] S_MIX     = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  // configuration registers
  logic                     blend_enable;
  logic                     relative_mode;
  logic signed [ELEV_W-1:0] range_min;
  logic signed [ELEV_W-1:0] range_max;

  // captured item
  logic [ACT_W-1:0]         act;
  logic signed [ELEV_W-1:0] elev_in;
  logic [COLOR_W-1:0]       new_color;
  ecr_entry_t               new_entry;

  // sequencer registers and their next values
  logic [3:0]          state,        state_next;
  logic [NW-1:0]       entry_count,  count_next;
  logic [IW-1:0]       k,            k_next;
  logic [IW-1:0]       scan_idx,     scan_next;
  ecr_entry_t          prev,         prev_next;
  logic [COLOR_W-1:0]  lo_color,     lo_next;
  logic [COLOR_W-1:0]  hi_color,     hi_next;
  logic [IW-1:0]       bracket,      bracket_next;
  logic [FRACTION_BITS-1:0] frac,    frac_next;
  logic [ELEV_W-1:0]   diff,         diff_next;
  logic [DW-1:0]       div_dividend, dividend_next;
  logic [ELEV_W-1:0]   div_divisor,  divisor_next;
  logic [COLOR_W-1:0]  res_color,    res_color_next;
  logic [STATUS_W-1:0] res_status,   res_status_next;

  // breakpoint table, one write and one registered read per cycle
  ecr_entry_t          bp_mem [ENTRIES];
  ecr_entry_t          rdata;
  ecr_entry_t          mem_wd;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  logic [IW-1:0]       mem_ra;

  // divider hookup
  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       div_q;

  // datapath helpers
  logic                item_accept;
  logic                out_load;
  logic [NW-1:0]       count_m1;
  logic signed [ELEV_W:0] span;
  logic signed [ELEV_W:0] rel_diff;
  logic signed [ELEV_W:0] abs_num;
  logic signed [ELEV_W:0] abs_den;
  logic                span_empty;
  logic signed [CH_W:0]   mix_dlt  [3];
  logic signed [FRACTION_BITS+CH_W+1:0] mix_prod [3];
  logic [COLOR_W-1:0]  mixed;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;
  assign new_entry   = '{elev: elev_in, color: new_color};
  assign count_m1    = entry_count - NW'(1);

  // 33-bit differences so no signed range can wrap
  assign span       = {range_max[ELEV_W-1], range_max} - {range_min[ELEV_W-1], range_min};
  assign rel_diff   = {elev_in[ELEV_W-1], elev_in} - {range_min[ELEV_W-1], range_min};
  assign abs_num    = {elev_in[ELEV_W-1], elev_in} - {prev.elev[ELEV_W-1], prev.elev};
  assign abs_den    = {rdata.elev[ELEV_W-1], rdata.elev} - {prev.elev[ELEV_W-1], prev.elev};
  assign span_empty = span[ELEV_W] || (span == '0);

  // lo + (hi - lo) * frac / 2^FRACTION_BITS, floor, per channel
  always_comb begin
    mixed = '0;
    for (int c = 0; c < 3; c++) begin
      mix_dlt[c]  = $signed({1'b0, hi_color[CH_W*c +: CH_W]}) -
                    $signed({1'b0, lo_color[CH_W*c +: CH_W]});
      mix_prod[c] = mix_dlt[c] * $signed({1'b0, frac});
      mixed[CH_W*c +: CH_W] = lo_color[CH_W*c +: CH_W] + mix_prod[c][FRACTION_BITS +: CH_W];
    end
  end

  // Shared divider: ((t * (count - 1)) << FRACTION_BITS) / range in relative mode gives the bracket in
  // the upper quotient bits and the fraction in the lower ones; in absolute mode the
  // upper bits come out zero and only the fraction is used.
  ecr_div #(
    .IDX_W         (IW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next      = state;
    count_next      = entry_count;
    k_next          = k;
    scan_next       = scan_idx;
    prev_next       = prev;
    lo_next         = lo_color;
    hi_next         = hi_color;
    bracket_next    = bracket;
    frac_next       = frac;
    diff_next       = diff;
    dividend_next   = div_dividend;
    divisor_next    = div_divisor;
    res_color_next  = res_color;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_wa          = '0;
    mem_wd          = new_entry;
    mem_ra          = '0;
    div_start       = 1'b0;

    case (state)
      S_IDLE: begin
        if (item_accept) begin
          state_next = S_START;
        end
      end

      S_START: begin
        // results default to zero color and ok status
        res_color_next  = '0;
        res_status_next = STATUS_OK;
        state_next      = S_DONE;
        case (act)
          ACT_INSERT: begin
            if (entry_count >= FULL_COUNT) begin
              res_status_next = STATUS_FULL;
            end else begin
              // walk down from the top, moving entries that are not smaller
              k_next = entry_count[IW-1:0];
              if (entry_count == '0) begin
                state_next = S_INS_PUT;
              end else begin
                mem_ra     = count_m1[IW-1:0];
                state_next = S_INS_CHK;
              end
            end
          end
          ACT_CLEAR: begin
            count_next = '0;
          end
          ACT_MAP: begin
            if (entry_count < MIN_MAP) begin
              res_status_next = STATUS_FEW;
            end else if (relative_mode) begin
              if (span_empty) begin
                res_status_next = STATUS_EMPTY_RANGE;
              end else if (elev_in <= range_min) begin
                mem_ra     = '0;
                state_next = S_END_RD;
              end else if (elev_in >= range_max) begin
                mem_ra     = count_m1[IW-1:0];
                state_next = S_END_RD;
              end else begin
                diff_next  = rel_diff[ELEV_W-1:0];
                state_next = S_MUL;
              end
            end else begin
              mem_ra     = '0;
              scan_next  = '0;
              state_next = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_INS_CHK: begin
        mem_we = 1'b1;
        mem_wa = k;
        if ($signed(rdata.elev) >= elev_in) begin
          // move this entry up one slot
          mem_wd = rdata;
          k_next = k - IW'(1);
          if (k == IW'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            mem_ra = k - IW'(2);
          end
        end else begin
          mem_wd     = new_entry;
          count_next = entry_count + NW'(1);
          state_next = S_DONE;
        end
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = k;
        mem_wd     = new_entry;
        count_next = entry_count + NW'(1);
        state_next = S_DONE;
      end

      S_MUL: begin
        dividend_next = DW'(diff) * DW'(count_m1[IW-1:0]);
        divisor_next  = span[ELEV_W-1:0];
        state_next    = S_DIVGO;
      end

      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          frac_next = div_q[FRACTION_BITS-1:0];
          if (relative_mode) begin
            bracket_next = div_q[QW-1:FRACTION_BITS];
            mem_ra       = div_q[QW-1:FRACTION_BITS];
            state_next   = S_REL_LO;
          end else begin
            state_next = S_MIX;
          end
        end
      end

      S_REL_LO: begin
        lo_next    = rdata.color;
        mem_ra     = bracket + IW'(1);
        state_next = S_REL_HI;
      end

      S_REL_HI: begin
        hi_next    = rdata.color;
        state_next = S_MIX;
      end

      S_SCAN: begin
        // stop at the first stored elevation above the sample
        if (elev_in < $signed(rdata.elev)) begin
          if (scan_idx == '0) begin
            res_color_next = rdata.color;
            state_next     = S_DONE;
          end else begin
            lo_next       = prev.color;
            hi_next       = rdata.color;
            dividend_next = DW'(abs_num[ELEV_W-1:0]);
            divisor_next  = abs_den[ELEV_W-1:0];
            state_next    = S_DIVGO;
          end
        end else if (scan_idx == count_m1[IW-1:0]) begin
          res_color_next = rdata.color;
          state_next     = S_DONE;
        end else begin
          prev_next = rdata;
          scan_next = scan_idx + IW'(1);
          mem_ra    = scan_idx + IW'(1);
        end
      end

      S_END_RD: begin
        res_color_next = rdata.color;
        state_next     = S_DONE;
      end

      S_MIX: begin
        res_color_next = blend_enable ? mixed : lo_color;
        state_next     = S_DONE;
      end

      S_DONE: begin
        // hand off once the output register is free
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_load = (state == S_DONE) && (!result_valid || !result_stall);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_enable  <= 1'b1;
      relative_mode <= 1'b1;
      range_min     <= '0;
      range_max     <= ELEV_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLEND_ENABLE:  blend_enable  <= cfg_data[0];
        CFG_RELATIVE_MODE: relative_mode <= cfg_data[0];
        CFG_RANGE_MIN:     range_min     <= $signed(cfg_data[ELEV_W-1:0]);
        CFG_RANGE_MAX:     range_max     <= $signed(cfg_data[ELEV_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_accept) begin
      act       <= action;
      elev_in   <= elevation;
      new_color <= {entry_red, entry_green, entry_blue};
    end
    k            <= k_next;
    scan_idx     <= scan_next;
    prev         <= prev_next;
    lo_color     <= lo_next;
    hi_color     <= hi_next;
    bracket      <= bracket_next;
    frac         <= frac_next;
    diff         <= diff_next;
    div_dividend <= dividend_next;
    div_divisor  <= divisor_next;
    res_color    <= res_color_next;
    res_status   <= res_status_next;
    if (out_load) begin
      red    <= res_color[2*CH_W +: CH_W];
      green  <= res_color[CH_W +: CH_W];
      blue   <= res_color[0 +: CH_W];
      status <= res_status;
    end
  end

  // breakpoint table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[mem_wa] <= mem_wd;
    end
    rdata <= bp_mem[mem_ra];
  end

  `ECR_ASSERT_ALWAYS(a_count_bound, entry_count <= FULL_COUNT, "entry count above table size")
  `ECR_ASSERT_IMPLY(a_error_no_color, result_valid && (status != STATUS_OK), (red == '0) && (green == '0) && (blue == '0), "error result carries a color")
  `ECR_ASSERT_NEXT(a_idle_count_hold, state == S_IDLE, $stable(entry_count), "entry count changed while idle")
  `ECR_ASSERT_IMPLY(a_div_done_state, div_done, state == S_DIV, "divider finished outside its wait state")

endmodule
